FILE: src/rdpm_pkg.sv
// rdpm_pkg: constants, register indexes, configuration struct and band helper
// for the roller deadband position mapper; no dependencies
`default_nettype none

package rdpm_pkg;

    localparam int unsigned SETPOINT_MID = 1000;

    localparam int unsigned MID   = SETPOINT_MID & 32'h7FFF;
    localparam int unsigned MID_W = (MID > 1) ? $clog2(MID + 1) : 1;
    localparam int unsigned NUM_W = MID_W + 16;
    localparam int unsigned CNT_W = $clog2(MID_W + 1);

    localparam logic [15:0] OUT_ERROR = 16'hFFFE;
    localparam logic [15:0] OUT_NONE  = 16'hFFFF;
    localparam logic [15:0] POS_RESET = 16'd2500;
    localparam logic [15:0] MID_VAL   = 16'(MID);
    localparam logic [15:0] MID_X2    = 16'(2 * MID);

    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_NEUTRAL_LOW   = 3'd0;
    localparam logic [2:0] REG_FULL_LOW      = 3'd1;
    localparam logic [2:0] REG_NEUTRAL_HIGH  = 3'd2;
    localparam logic [2:0] REG_FULL_HIGH     = 3'd3;
    localparam logic [2:0] REG_VALID_LOW     = 3'd4;
    localparam logic [2:0] REG_VALID_HIGH    = 3'd5;
    localparam logic [2:0] REG_CONNECTED     = 3'd6;
    localparam logic [2:0] REG_WAIT_NEUTRAL  = 3'd7;

    typedef struct packed {
        logic [15:0] neutral_low;
        logic [15:0] full_low;
        logic [15:0] neutral_high;
        logic [15:0] full_high;
        logic [15:0] valid_low;
        logic [15:0] valid_high;
        logic        channel_connected;
        logic        wait_neutral_start;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic value;
    } latch_ctl_t;

    function automatic logic pos_neutral(input logic [15:0] p, input cfg_t c);
        pos_neutral = !((p <= c.neutral_low) || (p >= c.neutral_high));
    endfunction

endpackage

`default_nettype wire

FILE: src/rdpm_regs.sv
// rdpm_regs: apb-style configuration registers of the position mapper
// depends on rdpm_pkg
`default_nettype none

module rdpm_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   reg_index,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output rdpm_pkg::cfg_t                    cfg,
    output rdpm_pkg::latch_ctl_t              latch_ctl
);

    rdpm_pkg::cfg_t cfg_reg;
    rdpm_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign wr_en = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_index)
                rdpm_pkg::REG_NEUTRAL_LOW:  cfg_next.neutral_low        = pwdata[15:0];
                rdpm_pkg::REG_FULL_LOW:     cfg_next.full_low           = pwdata[15:0];
                rdpm_pkg::REG_NEUTRAL_HIGH: cfg_next.neutral_high       = pwdata[15:0];
                rdpm_pkg::REG_FULL_HIGH:    cfg_next.full_high          = pwdata[15:0];
                rdpm_pkg::REG_VALID_LOW:    cfg_next.valid_low          = pwdata[15:0];
                rdpm_pkg::REG_VALID_HIGH:   cfg_next.valid_high         = pwdata[15:0];
                rdpm_pkg::REG_CONNECTED:    cfg_next.channel_connected  = pwdata[0];
                rdpm_pkg::REG_WAIT_NEUTRAL: cfg_next.wait_neutral_start = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.neutral_low        <= 16'd2400;
            cfg_reg.full_low           <= 16'd1000;
            cfg_reg.neutral_high       <= 16'd2600;
            cfg_reg.full_high          <= 16'd4000;
            cfg_reg.valid_low          <= 16'd250;
            cfg_reg.valid_high         <= 16'd4750;
            cfg_reg.channel_connected  <= 1'b1;
            cfg_reg.wait_neutral_start <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_index)
            rdpm_pkg::REG_NEUTRAL_LOW:  prdata = {16'd0, cfg_reg.neutral_low};
            rdpm_pkg::REG_FULL_LOW:     prdata = {16'd0, cfg_reg.full_low};
            rdpm_pkg::REG_NEUTRAL_HIGH: prdata = {16'd0, cfg_reg.neutral_high};
            rdpm_pkg::REG_FULL_HIGH:    prdata = {16'd0, cfg_reg.full_high};
            rdpm_pkg::REG_VALID_LOW:    prdata = {16'd0, cfg_reg.valid_low};
            rdpm_pkg::REG_VALID_HIGH:   prdata = {16'd0, cfg_reg.valid_high};
            rdpm_pkg::REG_CONNECTED:    prdata = {31'd0, cfg_reg.channel_connected};
            rdpm_pkg::REG_WAIT_NEUTRAL: prdata = {31'd0, cfg_reg.wait_neutral_start};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg             = cfg_reg;
    assign latch_ctl.load  = wr_en && (reg_index == rdpm_pkg::REG_WAIT_NEUTRAL);
    assign latch_ctl.value = pwdata[0];

endmodule

`default_nettype wire

FILE: src/rdpm_div.sv
// rdpm_div: restoring serial divider, one quotient bit per cycle
// depends on rdpm_pkg; quotient must fit in MID_W bits
`default_nettype none

module rdpm_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [rdpm_pkg::NUM_W-1:0]    numer,
    input  wire logic [15:0]                   denom,
    output logic                               done,
    output logic      [rdpm_pkg::MID_W-1:0]    quotient
);

    logic [15:0]                  rem_reg,  rem_next;
    logic [rdpm_pkg::MID_W-1:0]   qn_reg,   qn_next;
    logic [15:0]                  den_reg,  den_next;
    logic [rdpm_pkg::CNT_W-1:0]   cnt_reg,  cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [16:0]                  trial;
    logic                         fits;

    assign trial = {rem_reg, qn_reg[rdpm_pkg::MID_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        qn_next   = qn_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = numer[rdpm_pkg::NUM_W-1:rdpm_pkg::MID_W];
            qn_next   = numer[rdpm_pkg::MID_W-1:0];
            den_next  = denom;
            cnt_next  = rdpm_pkg::CNT_W'(rdpm_pkg::MID_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
            if (rdpm_pkg::MID_W > 1) begin
                qn_next = {qn_reg[rdpm_pkg::MID_W-2:0], fits};
            end else begin
                qn_next = rdpm_pkg::MID_W'(fits);
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rdpm_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        qn_reg  <= qn_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = qn_reg;

endmodule

`default_nettype wire

FILE: src/roller_deadband_position_mapper.sv
// roller_deadband_position_mapper: top level, sequencer around the shared divider
// depends on rdpm_pkg, rdpm_regs, rdpm_div
//
//  channel  ports                        handshake      payload
//  s_       s_valid / s_ready            valid-ready    s_sample_mv, s_fault_active
//  m_       m_valid / m_ready            valid-ready    m_drive_value, m_in_error
//  apb      psel penable pwrite paddr    setup+access   pwdata, prdata (pready tied high)
//
//  a ramp word steps from accept through EVAL, MUL and DIV to DONE, DIV waiting
//  for the serial divider, which produces one quotient bit per cycle; any other
//  word goes from EVAL straight to DONE; s_ready is low from accept until the result
//  is loaded into the output register; a stalled m_ready holds the sequencer
//  in its last step; synchronous reset, no clearing pass
`default_nettype none

module roller_deadband_position_mapper (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rdpm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [15:0]                   s_sample_mv,
    input  wire logic                          s_fault_active,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [15:0]                   m_drive_value,
    output logic                               m_in_error
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    rdpm_pkg::cfg_t        cfg;
    rdpm_pkg::latch_ctl_t  latch_ctl;

    logic [2:0]  state_reg,    state_next;
    logic [15:0] sample_reg,   sample_next;
    logic        fault_reg,    fault_next;
    logic [15:0] position_reg, position_next;
    logic        latch_reg,    latch_next;
    logic [15:0] held_reg,     held_next;
    logic [15:0] diff_reg,     diff_next;
    logic [15:0] den_reg,      den_next;
    logic        hi_reg,       hi_next;
    logic        mv_reg,       mv_next;
    logic [15:0] mdrive_reg,   mdrive_next;
    logic        merr_reg,     merr_next;

    logic [15:0]                 pos_new;
    logic                        div_start;
    logic                        div_done;
    logic [rdpm_pkg::NUM_W-1:0]  numer;
    logic [rdpm_pkg::MID_W-1:0]  quotient;

    rdpm_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .reg_index (paddr[4:2]),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .cfg       (cfg),
        .latch_ctl (latch_ctl)
    );

    assign numer = rdpm_pkg::NUM_W'(rdpm_pkg::MID) * rdpm_pkg::NUM_W'(diff_reg);

    rdpm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (numer),
        .denom    (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign pos_new = ((sample_reg < cfg.valid_low) || (sample_reg > cfg.valid_high))
                   ? position_reg : sample_reg;

    always_comb begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        fault_next    = fault_reg;
        position_next = position_reg;
        latch_next    = latch_reg;
        held_next     = held_reg;
        diff_next     = diff_reg;
        den_next      = den_reg;
        hi_next       = hi_reg;
        mv_next       = mv_reg;
        mdrive_next   = mdrive_reg;
        merr_next     = merr_reg;
        div_start     = 1'b0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        if (latch_ctl.load) begin
            latch_next = latch_ctl.value;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_sample_mv;
                    fault_next  = s_fault_active;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_DONE;
                if (!cfg.channel_connected) begin
                    held_next  = rdpm_pkg::OUT_NONE;
                    latch_next = 1'b0;
                end else begin
                    position_next = pos_new;
                    if (latch_reg) begin
                        held_next = rdpm_pkg::OUT_ERROR;
                        if (!fault_reg && rdpm_pkg::pos_neutral(pos_new, cfg)) begin
                            latch_next = 1'b0;
                        end
                    end else if (fault_reg) begin
                        latch_next = 1'b1;
                    end else if (rdpm_pkg::pos_neutral(pos_new, cfg)) begin
                        held_next = rdpm_pkg::MID_VAL;
                    end else if (pos_new >= cfg.full_high) begin
                        held_next = rdpm_pkg::MID_X2;
                    end else if (pos_new <= cfg.full_low) begin
                        held_next = 16'd0;
                    end else if ((pos_new >= cfg.neutral_high)
                                 && (cfg.full_high > cfg.neutral_high)) begin
                        diff_next  = pos_new - cfg.neutral_high;
                        den_next   = cfg.full_high - cfg.neutral_high;
                        hi_next    = 1'b1;
                        state_next = ST_MUL;
                    end else if ((pos_new <= cfg.neutral_low)
                                 && (cfg.neutral_low > cfg.full_low)) begin
                        diff_next  = cfg.neutral_low - pos_new;
                        den_next   = cfg.neutral_low - cfg.full_low;
                        hi_next    = 1'b0;
                        state_next = ST_MUL;
                    end else begin
                        held_next = rdpm_pkg::OUT_NONE;
                    end
                end
            end
            ST_MUL: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    held_next  = hi_reg ? (rdpm_pkg::MID_VAL + 16'(quotient))
                                        : (rdpm_pkg::MID_VAL - 16'(quotient));
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next     = 1'b1;
                    mdrive_next = held_reg;
                    merr_next   = latch_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            position_reg <= rdpm_pkg::POS_RESET;
            latch_reg    <= 1'b1;
            held_reg     <= rdpm_pkg::OUT_NONE;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            position_reg <= position_next;
            latch_reg    <= latch_next;
            held_reg     <= held_next;
            mv_reg       <= mv_next;
        end
        sample_reg <= sample_next;
        fault_reg  <= fault_next;
        diff_reg   <= diff_next;
        den_reg    <= den_next;
        hi_reg     <= hi_next;
        mdrive_reg <= mdrive_next;
        merr_reg   <= merr_next;
    end

    assign pready        = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = mv_reg;
    assign m_drive_value = mdrive_reg;
    assign m_in_error    = merr_reg;

endmodule

`default_nettype wire
